FILE: src/i2cbl_pkg.sv
// Package for the I2C bootloader command engine: payload structs, codes,
// state encoding and the fixed info record. No dependencies.
package i2cbl_pkg;

   // Default buffer size in 16-bit words.
   localparam int BUFFER_WORDS_DEFAULT = 64;

   // Reset values of the configuration registers.
   localparam logic [15:0] FLASH_WORDS_TOTAL_RESET    = 16'd4096;
   localparam logic [8:0]  FLASH_ROW_WORDS_RESET      = 9'd32;
   localparam logic [15:0] LOADER_START_ADDRESS_RESET = 16'h0E00;

   // Configuration register indexes.
   localparam logic [1:0] CSR_FLASH_WORDS_TOTAL    = 2'd0;
   localparam logic [1:0] CSR_FLASH_ROW_WORDS      = 2'd1;
   localparam logic [1:0] CSR_LOADER_START_ADDRESS = 2'd2;

   // Bus event codes.
   localparam logic [1:0] OP_ADDR_WRITE = 2'd0;
   localparam logic [1:0] OP_ADDR_READ  = 2'd1;
   localparam logic [1:0] OP_DATA_WRITE = 2'd2;
   localparam logic [1:0] OP_DATA_READ  = 2'd3;

   // Result action codes.
   localparam logic [2:0] ACT_REPLY     = 3'd0;
   localparam logic [2:0] ACT_LATCH     = 3'd1;
   localparam logic [2:0] ACT_ROW_WRITE = 3'd2;
   localparam logic [2:0] ACT_ROW_ERASE = 3'd3;
   localparam logic [2:0] ACT_RUN_APP   = 3'd4;
   localparam logic [2:0] ACT_RESTART   = 3'd5;

   // Command codes held in the low byte of word 0.
   localparam logic [7:0] CMD_SYNC   = 8'd1;
   localparam logic [7:0] CMD_INFO   = 8'd2;
   localparam logic [7:0] CMD_BOOT   = 8'd3;
   localparam logic [7:0] CMD_REBOOT = 8'd4;
   localparam logic [7:0] CMD_WRITE  = 8'd11;
   localparam logic [7:0] CMD_ERASE  = 8'd21;

   // Info record geometry.
   localparam int INFO_WORDS = 19;
   localparam int INFO_BYTES = 38;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] bus_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  reply_byte;
      logic [15:0] flash_address;
      logic [15:0] flash_word;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MERGE,
      ST_READ,
      ST_CMD,
      ST_INFO,
      ST_RUN,
      ST_ERASE,
      ST_WADDR,
      ST_WCNT,
      ST_WLOOP,
      ST_RESTART,
      ST_REPLY
   } state_type;

   // One word of the info record, selected by its word index.
   function automatic logic [15:0] info_word(input logic [4:0]  idx,
                                             input logic [15:0] total,
                                             input logic [8:0]  row,
                                             input logic [15:0] start);
      logic [15:0] w;
      case (idx)
         5'd0:    w = 16'(INFO_BYTES);
         5'd1:    w = 16'd1;
         5'd2:    w = 16'd1;
         5'd3:    w = 16'd8;
         5'd4:    w = total;
         5'd5:    w = 16'd3;
         5'd6:    w = {7'd0, row};
         5'd7:    w = 16'd4;
         5'd8:    w = {7'd0, row};
         5'd9:    w = 16'd5;
         5'd10:   w = 16'h0100;
         5'd11:   w = 16'd6;
         5'd12:   w = start;
         5'd13:   w = 16'd7;
         5'd14:   w = 16'h7542;
         5'd15:   w = 16'h6b63;
         5'd16:   w = 16'h4320;
         5'd17:   w = 16'h696c;
         5'd18:   w = 16'h6b63;
         default: w = 16'd0;
      endcase
      return w;
   endfunction

endpackage

FILE: src/i2cbl_rsp_reg.sv
// Output register of the I2C bootloader command engine result channel.
// Depends on i2cbl_pkg for the result struct.
module i2cbl_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  i2cbl_pkg::rsp_type push_data,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output i2cbl_pkg::rsp_type rsp_data
);

   logic               valid_ff;
   i2cbl_pkg::rsp_type data_ff;

   // A new result may enter when the register is empty or is drained now.
   assign free      = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (push) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_data;
      end
   end

endmodule

FILE: src/i2c_bootloader_command_engine_core.sv
// Top level of the I2C bootloader command engine: command sequencer around the
// word buffer memory. Depends on i2cbl_pkg and i2cbl_rsp_reg.
//
// Usage: bus events arrive on the req_ channel (valid/stall), one request at a
// time; results leave on the rsp_ channel (valid/stall) through an output
// register, so a pending result never blocks the next request. Registers are
// written on the csr_ channel, which is always ready.
// Request handling, around the single-port buffer memory with its registered read:
//   address for write   no result.
//   data write          read, then merge and write back.
//   data read           read, then reply.
//   address for read    read word 0 and decode; sync/boot reply, reboot/erase
//                       push their action first, info writes the record first
//                       (one record word written per cycle), unknown command
//                       restarts, write command reads address and count, then
//                       one latch or row write result per cycle unless stalled.
// The request side stalls while a request is at work, and the sequencer holds
// in place while the receiver stalls the result channel.
// Reset clears position, count and the per-word valid bits at once; a word
// that is not valid reads as zero, so no clearing pass is needed. An unknown
// command clears them the same way. Register values return to their defaults.
module i2c_bootloader_command_engine_core #(
   parameter int BUFFER_WORDS = i2cbl_pkg::BUFFER_WORDS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  i2cbl_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output i2cbl_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);

   localparam int BUF_BYTES = 2 * BUFFER_WORDS;
   localparam int POS_W     = $clog2(BUF_BYTES);
   localparam int WI_W      = $clog2(BUFFER_WORDS);
   localparam int CNT_W     = $clog2(BUF_BYTES + 1);
   localparam int INFO_CNT  = (i2cbl_pkg::INFO_BYTES < BUF_BYTES) ?
                              i2cbl_pkg::INFO_BYTES : BUF_BYTES;

   localparam logic [CNT_W-1:0] BUF_BYTES_C = CNT_W'(BUF_BYTES);
   localparam logic [CNT_W-1:0] INFO_CNT_C  = CNT_W'(INFO_CNT);
   localparam logic [POS_W-1:0] POS_LAST    = POS_W'(BUF_BYTES - 1);
   localparam logic [15:0]      MAX_WORDS16 = 16'(BUFFER_WORDS - 3);
   localparam logic [WI_W-1:0]  MAX_WORDS   = WI_W'(BUFFER_WORDS - 3);
   localparam logic [4:0]       INFO_LAST   = 5'(i2cbl_pkg::INFO_WORDS - 1);

   // Configuration registers.
   logic [15:0] total_ff;
   logic [8:0]  row_ff;
   logic [15:0] start_ff;

   // Sequencer state.
   i2cbl_pkg::state_type state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [7:0]       byte_ff, byte_in;
   logic [15:0]      addr_ff, addr_in;
   logic [WI_W-1:0]  rem_ff, rem_in;
   logic [WI_W-1:0]  widx_ff, widx_in;
   logic [4:0]       idx_ff, idx_in;

   // Buffer memory and its valid bits.
   logic [15:0]             mem [BUFFER_WORDS];
   logic [BUFFER_WORDS-1:0] vld_ff;
   logic [15:0]             rd_data_ff;
   logic                    rd_vld_ff;
   logic                    rd_en;
   logic [WI_W-1:0]         rd_addr;
   logic                    wr_en;
   logic [WI_W-1:0]         wr_addr;
   logic [15:0]             wr_data;
   logic                    vld_clear;
   logic [15:0]             rd_word;

   // Result path.
   logic               push;
   i2cbl_pkg::rsp_type push_data;
   logic               out_free;

   logic [WI_W-1:0]  pos_word;
   logic [POS_W-1:0] pos_next;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != i2cbl_pkg::ST_IDLE);
   assign rd_word   = rd_vld_ff ? rd_data_ff : 16'd0;
   assign pos_word  = pos_ff[POS_W-1:1];
   assign pos_next  = (pos_ff == POS_LAST) ? '0 : pos_ff + POS_W'(1);

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= i2cbl_pkg::FLASH_WORDS_TOTAL_RESET;
         row_ff   <= i2cbl_pkg::FLASH_ROW_WORDS_RESET;
         start_ff <= i2cbl_pkg::LOADER_START_ADDRESS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            i2cbl_pkg::CSR_FLASH_WORDS_TOTAL:    total_ff <= csr_data;
            i2cbl_pkg::CSR_FLASH_ROW_WORDS:      row_ff   <= csr_data[8:0];
            i2cbl_pkg::CSR_LOADER_START_ADDRESS: start_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Single-port word buffer with a registered read. Accesses never overlap:
   // a merged byte is written back before the sequencer returns to idle, so
   // the next read always sees it.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   // A word that was never written since reset or restart reads as zero.
   always_ff @(posedge clock) begin
      if (reset || vld_clear) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= i2cbl_pkg::ST_IDLE;
         pos_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      byte_ff <= byte_in;
      addr_ff <= addr_in;
      rem_ff  <= rem_in;
      widx_ff <= widx_in;
      idx_ff  <= idx_in;
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      cmd_in    = cmd_ff;
      byte_in   = byte_ff;
      addr_in   = addr_ff;
      rem_in    = rem_ff;
      widx_in   = widx_ff;
      idx_in    = idx_ff;
      rd_en     = 1'b0;
      rd_addr   = pos_word;
      wr_en     = 1'b0;
      wr_addr   = pos_word;
      wr_data   = rd_word;
      vld_clear = 1'b0;
      push      = 1'b0;
      push_data = '0;

      case (state_ff)
         i2cbl_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_data.op)
                  i2cbl_pkg::OP_ADDR_WRITE: begin
                     pos_in = '0;
                     cnt_in = '0;
                  end
                  i2cbl_pkg::OP_DATA_WRITE: begin
                     // A full buffer drops the byte.
                     if (cnt_ff < BUF_BYTES_C) begin
                        rd_en    = 1'b1;
                        byte_in  = req_data.bus_byte;
                        state_in = i2cbl_pkg::ST_MERGE;
                     end
                  end
                  i2cbl_pkg::OP_DATA_READ: begin
                     if (cnt_ff != '0) begin
                        rd_en    = 1'b1;
                        state_in = i2cbl_pkg::ST_READ;
                     end else begin
                        cmd_in   = 8'd0;
                        state_in = i2cbl_pkg::ST_REPLY;
                     end
                  end
                  i2cbl_pkg::OP_ADDR_READ: begin
                     pos_in = '0;
                     if (cnt_ff < CNT_W'(2)) begin
                        cmd_in   = 8'd0;
                        state_in = i2cbl_pkg::ST_REPLY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = i2cbl_pkg::ST_CMD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         i2cbl_pkg::ST_MERGE: begin
            wr_en    = 1'b1;
            wr_data  = pos_ff[0] ? {byte_ff, rd_word[7:0]} : {rd_word[15:8], byte_ff};
            pos_in   = pos_next;
            cnt_in   = cnt_ff + CNT_W'(1);
            state_in = i2cbl_pkg::ST_IDLE;
         end

         i2cbl_pkg::ST_READ: begin
            if (out_free) begin
               push                 = 1'b1;
               push_data.action     = i2cbl_pkg::ACT_REPLY;
               push_data.reply_byte = pos_ff[0] ? rd_word[15:8] : rd_word[7:0];
               push_data.last       = 1'b1;
               pos_in               = pos_next;
               cnt_in               = cnt_ff - CNT_W'(1);
               state_in             = i2cbl_pkg::ST_IDLE;
            end
         end

         i2cbl_pkg::ST_CMD: begin
            cmd_in = rd_word[7:0];
            case (rd_word[7:0])
               i2cbl_pkg::CMD_SYNC,
               i2cbl_pkg::CMD_BOOT: state_in = i2cbl_pkg::ST_REPLY;
               i2cbl_pkg::CMD_INFO: begin
                  idx_in   = '0;
                  state_in = i2cbl_pkg::ST_INFO;
               end
               i2cbl_pkg::CMD_REBOOT: state_in = i2cbl_pkg::ST_RUN;
               i2cbl_pkg::CMD_ERASE: begin
                  rd_en    = 1'b1;
                  rd_addr  = WI_W'(1);
                  state_in = i2cbl_pkg::ST_ERASE;
               end
               i2cbl_pkg::CMD_WRITE: begin
                  rd_en    = 1'b1;
                  rd_addr  = WI_W'(1);
                  state_in = i2cbl_pkg::ST_WADDR;
               end
               default: state_in = i2cbl_pkg::ST_RESTART;
            endcase
         end

         i2cbl_pkg::ST_INFO: begin
            // Record words beyond the buffer end are dropped.
            if (int'(idx_ff) < BUFFER_WORDS) begin
               wr_en   = 1'b1;
               wr_addr = WI_W'(idx_ff);
               wr_data = i2cbl_pkg::info_word(idx_ff, total_ff, row_ff, start_ff);
            end
            idx_in = idx_ff + 5'd1;
            if (idx_ff == INFO_LAST) begin
               cnt_in   = INFO_CNT_C;
               state_in = i2cbl_pkg::ST_REPLY;
            end
         end

         i2cbl_pkg::ST_RUN: begin
            if (out_free) begin
               push             = 1'b1;
               push_data.action = i2cbl_pkg::ACT_RUN_APP;
               state_in         = i2cbl_pkg::ST_REPLY;
            end
         end

         i2cbl_pkg::ST_ERASE: begin
            if (out_free) begin
               push                    = 1'b1;
               push_data.action        = i2cbl_pkg::ACT_ROW_ERASE;
               push_data.flash_address = rd_word;
               state_in                = i2cbl_pkg::ST_REPLY;
            end
         end

         i2cbl_pkg::ST_WADDR: begin
            addr_in  = rd_word;
            rd_en    = 1'b1;
            rd_addr  = WI_W'(2);
            state_in = i2cbl_pkg::ST_WCNT;
         end

         i2cbl_pkg::ST_WCNT: begin
            // Word count is clamped to the buffer and a zero count acts as one.
            if (rd_word > MAX_WORDS16) begin
               rem_in = MAX_WORDS;
            end else if (rd_word == 16'd0) begin
               rem_in = WI_W'(1);
            end else begin
               rem_in = rd_word[WI_W-1:0];
            end
            rd_en    = 1'b1;
            rd_addr  = WI_W'(3);
            widx_in  = WI_W'(3);
            state_in = i2cbl_pkg::ST_WLOOP;
         end

         i2cbl_pkg::ST_WLOOP: begin
            // The read of the next word is issued only when the current one is
            // taken, so the read register holds it across a stall.
            if (out_free) begin
               push                    = 1'b1;
               push_data.action        = (rem_ff == WI_W'(1)) ?
                                         i2cbl_pkg::ACT_ROW_WRITE : i2cbl_pkg::ACT_LATCH;
               push_data.flash_address = addr_ff;
               push_data.flash_word    = rd_word;
               addr_in                 = addr_ff + 16'd1;
               rem_in                  = rem_ff - WI_W'(1);
               if (rem_ff == WI_W'(1)) begin
                  state_in = i2cbl_pkg::ST_REPLY;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = widx_ff + WI_W'(1);
                  widx_in = widx_ff + WI_W'(1);
               end
            end
         end

         i2cbl_pkg::ST_RESTART: begin
            if (out_free) begin
               push             = 1'b1;
               push_data.action = i2cbl_pkg::ACT_RESTART;
               vld_clear        = 1'b1;
               pos_in           = '0;
               cnt_in           = '0;
               state_in         = i2cbl_pkg::ST_REPLY;
            end
         end

         i2cbl_pkg::ST_REPLY: begin
            if (out_free) begin
               push                 = 1'b1;
               push_data.action     = i2cbl_pkg::ACT_REPLY;
               push_data.reply_byte = cmd_ff;
               push_data.last       = 1'b1;
               state_in             = i2cbl_pkg::ST_IDLE;
            end
         end

         default: state_in = i2cbl_pkg::ST_IDLE;
      endcase
   end

   i2cbl_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
